[hdl/nq_pkg.sv]
`default_nettype none
package nq_pkg;

    localparam int MAX_SIZE    = 16;
    localparam int RESULT_MAX  = 16;
    localparam int SIZE_LIMIT  = (MAX_SIZE < RESULT_MAX) ? MAX_SIZE : RESULT_MAX;
    localparam int IDX_W       = $clog2(MAX_SIZE);
    localparam int ROW_W       = $clog2(MAX_SIZE + 1);
    localparam int DIAG_N      = 2 * MAX_SIZE - 1;
    localparam int DIAG_W      = $clog2(DIAG_N);

    // outcome of one probe of the shared attack unit
    typedef struct packed {
        logic                free;
        logic [MAX_SIZE-1:0] col_bit;
        logic [DIAG_N-1:0]   down_bit;
        logic [DIAG_N-1:0]   up_bit;
    } nq_probe_t;

endpackage
`default_nettype wire

[hdl/nq_probe.sv]
`default_nettype none
module nq_probe (
    input  wire logic [nq_pkg::IDX_W-1:0]    row,
    input  wire logic [nq_pkg::IDX_W-1:0]    col,
    input  wire logic [nq_pkg::ROW_W-1:0]    size,
    input  wire logic [nq_pkg::MAX_SIZE-1:0] used_cols,
    input  wire logic [nq_pkg::DIAG_N-1:0]   used_down,
    input  wire logic [nq_pkg::DIAG_N-1:0]   used_up,
    output nq_pkg::nq_probe_t                probe
);

    logic [nq_pkg::DIAG_W-1:0] down_idx;
    logic [nq_pkg::DIAG_W-1:0] up_idx;

    always_comb begin
        down_idx = nq_pkg::DIAG_W'(row) + nq_pkg::DIAG_W'(col);
        // row + n - 1 - col, never negative for a legal square
        up_idx   = nq_pkg::DIAG_W'(row) + nq_pkg::DIAG_W'(size)
                 - nq_pkg::DIAG_W'(1) - nq_pkg::DIAG_W'(col);

        probe.col_bit  = {{(nq_pkg::MAX_SIZE-1){1'b0}}, 1'b1} << col;
        probe.down_bit = {{(nq_pkg::DIAG_N-1){1'b0}}, 1'b1} << down_idx;
        probe.up_bit   = {{(nq_pkg::DIAG_N-1){1'b0}}, 1'b1} << up_idx;
        probe.free     = ((used_cols & probe.col_bit) == '0)
                       && ((used_down & probe.down_bit) == '0)
                       && ((used_up & probe.up_bit) == '0);
    end

endmodule
`default_nettype wire

[hdl/n_queens_first_solution.sv]
// First N-queens placement by depth-first backtracking, one search step per cycle.
// The request is registered when taken; then each search step (place, advance
// candidate or backtrack) goes through the shared attack probe, then N results.
// Throughput: one request at a time; s_ready is high only when no request is open.
// Invalid sizes (0, too large) and N of 2 or 3 give one found = 0 result.
// Reset: synchronous active-low aresetn clears the sequencer, masks and result valid.
`default_nettype none
module n_queens_first_solution (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [4:0] s_board_size,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [3:0]      m_row_index,
    output logic [3:0]      m_queen_column,
    output logic            m_found,
    output logic            m_last
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_OUT    = 2'd2;

    logic [1:0]                   state_reg, state_next;
    logic [nq_pkg::ROW_W-1:0]     row_reg, row_next;
    logic [nq_pkg::ROW_W-1:0]     cand_reg, cand_next;
    logic [nq_pkg::ROW_W-1:0]     size_reg, size_next;
    logic                         found_reg, found_next;
    logic                         m_valid_reg, m_valid_next;
    logic [nq_pkg::MAX_SIZE-1:0]  cols_reg, cols_next;
    logic [nq_pkg::DIAG_N-1:0]    down_reg, down_next;
    logic [nq_pkg::DIAG_N-1:0]    up_reg, up_next;

    logic [nq_pkg::IDX_W-1:0]     placed_reg [nq_pkg::MAX_SIZE];
    logic                         placed_we;
    logic [nq_pkg::ROW_W-1:0]     rd_row;
    logic [nq_pkg::IDX_W-1:0]     rd_data;

    logic                         backtrack;
    logic [nq_pkg::IDX_W-1:0]     probe_row;
    logic [nq_pkg::IDX_W-1:0]     probe_col;
    nq_pkg::nq_probe_t            probe;
    logic                         size_bad;

    // single read port: previous row while searching, output row while sending
    assign rd_row  = (state_reg == ST_OUT) ? row_reg : row_reg - nq_pkg::ROW_W'(1);
    assign rd_data = placed_reg[rd_row[nq_pkg::IDX_W-1:0]];

    assign backtrack = (cand_reg >= size_reg) && (row_reg != '0);
    assign probe_row = backtrack ? rd_row[nq_pkg::IDX_W-1:0] : row_reg[nq_pkg::IDX_W-1:0];
    assign probe_col = backtrack ? rd_data : cand_reg[nq_pkg::IDX_W-1:0];

    nq_probe u_probe (
        .row       (probe_row),
        .col       (probe_col),
        .size      (size_reg),
        .used_cols (cols_reg),
        .used_down (down_reg),
        .used_up   (up_reg),
        .probe     (probe)
    );

    assign size_bad = (s_board_size == 5'd0) || (s_board_size > 5'(nq_pkg::SIZE_LIMIT));

    always_comb begin
        state_next   = state_reg;
        row_next     = row_reg;
        cand_next    = cand_reg;
        size_next    = size_reg;
        found_next   = found_reg;
        m_valid_next = m_valid_reg;
        cols_next    = cols_reg;
        down_next    = down_reg;
        up_next      = up_reg;
        placed_we    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    row_next  = '0;
                    cand_next = '0;
                    cols_next = '0;
                    down_next = '0;
                    up_next   = '0;
                    if (size_bad) begin
                        size_next    = '0;
                        found_next   = 1'b0;
                        m_valid_next = 1'b1;
                        state_next   = ST_OUT;
                    end else begin
                        size_next  = nq_pkg::ROW_W'(s_board_size);
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (row_reg >= size_reg) begin
                    row_next     = '0;
                    found_next   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_OUT;
                end else if (cand_reg >= size_reg) begin
                    if (row_reg == '0) begin
                        found_next   = 1'b0;
                        m_valid_next = 1'b1;
                        state_next   = ST_OUT;
                    end else begin
                        // lift the queen of the previous row, resume right of it
                        cols_next = cols_reg ^ probe.col_bit;
                        down_next = down_reg ^ probe.down_bit;
                        up_next   = up_reg ^ probe.up_bit;
                        row_next  = rd_row;
                        cand_next = nq_pkg::ROW_W'(rd_data) + nq_pkg::ROW_W'(1);
                    end
                end else if (probe.free) begin
                    placed_we = 1'b1;
                    cols_next = cols_reg ^ probe.col_bit;
                    down_next = down_reg ^ probe.down_bit;
                    up_next   = up_reg ^ probe.up_bit;
                    row_next  = row_reg + nq_pkg::ROW_W'(1);
                    cand_next = '0;
                end else begin
                    cand_next = cand_reg + nq_pkg::ROW_W'(1);
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (m_last) begin
                        m_valid_next = 1'b0;
                        state_next   = ST_IDLE;
                    end else begin
                        row_next = row_reg + nq_pkg::ROW_W'(1);
                    end
                end
            end
            default: begin
                state_next   = ST_IDLE;
                m_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            row_reg     <= '0;
            cand_reg    <= '0;
            size_reg    <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            cols_reg    <= '0;
            down_reg    <= '0;
            up_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            cand_reg    <= cand_next;
            size_reg    <= size_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
            cols_reg    <= cols_next;
            down_reg    <= down_next;
            up_reg      <= up_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (placed_we) begin
            placed_reg[row_reg[nq_pkg::IDX_W-1:0]] <= cand_reg[nq_pkg::IDX_W-1:0];
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_found        = found_reg;
    assign m_row_index    = found_reg ? 4'(row_reg) : 4'd0;
    assign m_queen_column = found_reg ? 4'(rd_data) : 4'd0;
    assign m_last         = !found_reg || (row_reg == size_reg - nq_pkg::ROW_W'(1));

endmodule
`default_nettype wire
